FILE: src/rne_pkg.sv
// Shared constants and letter lookup for the Roman numeral encoder.
package rne_pkg;

  localparam int unsigned ROMAN_MAX   = 3999;
  localparam logic [6:0]  ASCII_ZERO  = 7'h30;
  localparam logic [6:0]  ASCII_MINUS = 7'h2d;
  localparam logic [6:0]  CASE_BIT    = 7'h20;

  // letter index: 0 I, 1 V, 2 X, 3 L, 4 C, 5 D, 6 M
  function automatic logic [6:0] roman_letter(input logic [2:0] idx, input logic upper);
    logic [6:0] ch;
    case (idx)
      3'd0:    ch = 7'h49;
      3'd1:    ch = 7'h56;
      3'd2:    ch = 7'h58;
      3'd3:    ch = 7'h4c;
      3'd4:    ch = 7'h43;
      3'd5:    ch = 7'h44;
      3'd6:    ch = 7'h4d;
      default: ch = 7'h4d;
    endcase
    return upper ? ch : (ch | CASE_BIT);
  endfunction

endpackage

FILE: src/rne_bcd_conv.sv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
module rne_bcd_conv #(
  parameter int W    = 16,
  parameter int NDIG = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [W-1:0]      mag,
  output logic              done,
  output logic [NDIG*4-1:0] bcd
);

  localparam int NB = NDIG * 4;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  shreg_r, shreg_nxt;
  logic [NB-1:0] bcd_r, bcd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [NB-1:0] adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? (bcd_r[i*4 +: 4] + 4'd3) : bcd_r[i*4 +: 4];
    end
  end

  always_comb begin
    shreg_nxt = shreg_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      shreg_nxt = mag;
      bcd_nxt   = '0;
      cnt_nxt   = CW'(W);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      shreg_nxt = {shreg_r[W-2:0], 1'b0};
      bcd_nxt   = {adj[NB-2:0], shreg_r[W-1]};
      cnt_nxt   = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    shreg_r <= shreg_nxt;
    bcd_r   <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

FILE: src/roman_numeral_encoder_core.sv
// Roman numeral encoder top level: digit conversion, character sequencer, output register.
// Flow: shift/add-3 BCD conversion, a handoff to the sequencer, then one character per cycle
//   into the output register while its slot is free (a zero Roman digit or a leading zero
//   takes a sequencer step with no character). A new value is taken only after the last
//   character is written; in_stall is high from acceptance to the last character.
// Reset (synchronous, rst_n low): sequencer idle, output empty, upper_case cleared to lowercase.
module roman_numeral_encoder_core #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [6:0]                    out_char_code,
  output logic                          out_last_char,
  output logic                          out_is_fallback
);
  import rne_pkg::*;

  localparam int W    = VALUE_WIDTH;
  // enough decimal digits for the largest magnitude, 2^(W-1)
  localparam int NDIG = VALUE_WIDTH * 3 / 10 + 1;
  localparam int NB   = NDIG * 4;
  localparam int DW   = $clog2(NDIG);

  typedef enum logic [2:0] {
    IDLE,
    CONV,
    SIGN,
    ROMAN,
    DEC
  } state_t;

  state_t        state_r, state_nxt;
  logic          upper_r;
  logic          neg_r, neg_nxt;
  logic          fb_r, fb_nxt;
  logic [DW-1:0] pos_r, pos_nxt;
  logic [1:0]    sub_r, sub_nxt;
  logic          started_r, started_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [6:0]    out_char_r, out_char_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_fb_r, out_fb_nxt;

  logic [W-1:0]  raw_u;
  logic          in_neg;
  logic          in_roman;
  logic [W-1:0]  in_mag;
  logic          conv_start;
  logic          conv_done;
  logic [NB-1:0] bcd;

  // input decode: Roman only for 1..3999, magnitude in W bits (most negative stays 2^(W-1))
  assign raw_u    = $unsigned(in_value);
  assign in_neg   = raw_u[W-1];
  assign in_roman = !in_neg && (raw_u != '0) && (raw_u <= W'(ROMAN_MAX));
  assign in_mag   = in_neg ? (~raw_u + W'(1)) : raw_u;

  assign in_stall   = (state_r != IDLE);
  assign conv_start = in_valid && (state_r == IDLE);

  rne_bcd_conv #(
    .W    (W),
    .NDIG (NDIG)
  ) u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .mag   (in_mag),
    .done  (conv_done),
    .bcd   (bcd)
  );

  // current decimal digit and whether all digits below it are zero
  logic [3:0] dig;
  logic       low_zero;
  assign dig      = bcd[pos_r*4 +: 4];
  assign low_zero = ((bcd & ~({NB{1'b1}} << {pos_r, 2'b00})) == '0);

  // Roman letters for this decade: one at 2*pos, five and ten above it
  logic [2:0] one_idx;
  logic [6:0] one_ch, five_ch, ten_ch;
  logic [2:0] r_len;
  logic [6:0] r_ch;
  assign one_idx = {pos_r[1:0], 1'b0};
  assign one_ch  = roman_letter(one_idx, upper_r);
  assign five_ch = roman_letter(one_idx + 3'd1, upper_r);
  assign ten_ch  = roman_letter(one_idx + 3'd2, upper_r);

  always_comb begin
    r_len = 3'd0;
    r_ch  = one_ch;
    case (dig)
      4'd1, 4'd2, 4'd3: r_len = dig[2:0];
      4'd4: begin
        r_len = 3'd2;
        r_ch  = (sub_r == 2'd0) ? one_ch : five_ch;
      end
      4'd5, 4'd6, 4'd7, 4'd8: begin
        r_len = dig[2:0] - 3'd4;
        r_ch  = (sub_r == 2'd0) ? five_ch : one_ch;
      end
      4'd9: begin
        r_len = 3'd2;
        r_ch  = (sub_r == 2'd0) ? one_ch : ten_ch;
      end
      default: r_len = 3'd0;
    endcase
  end

  logic       slot_free;
  logic       emit;
  logic [6:0] emit_ch;
  logic       emit_last;
  logic       r_digit_end;

  assign slot_free   = !out_valid_r || !out_stall;
  assign r_digit_end = ({1'b0, sub_r} == r_len - 3'd1);

  always_comb begin
    state_nxt   = state_r;
    neg_nxt     = neg_r;
    fb_nxt      = fb_r;
    pos_nxt     = pos_r;
    sub_nxt     = sub_r;
    started_nxt = started_r;
    emit        = 1'b0;
    emit_ch     = ASCII_ZERO;
    emit_last   = 1'b0;
    case (state_r)
      IDLE: begin
        if (in_valid) begin
          neg_nxt   = in_neg;
          fb_nxt    = !in_roman;
          state_nxt = CONV;
        end
      end
      CONV: begin
        if (conv_done) begin
          sub_nxt     = 2'd0;
          started_nxt = 1'b0;
          if (fb_r) begin
            pos_nxt   = DW'(NDIG - 1);
            state_nxt = neg_r ? SIGN : DEC;
          end else begin
            pos_nxt   = DW'(3);
            state_nxt = ROMAN;
          end
        end
      end
      SIGN: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_ch   = ASCII_MINUS;
          state_nxt = DEC;
        end
      end
      ROMAN: begin
        if (r_len == 3'd0) begin
          // zero digit: nothing to write
          pos_nxt = pos_r - DW'(1);
        end else if (slot_free) begin
          emit      = 1'b1;
          emit_ch   = r_ch;
          emit_last = r_digit_end && low_zero;
          if (r_digit_end) begin
            sub_nxt = 2'd0;
            pos_nxt = pos_r - DW'(1);
            if (low_zero) begin
              state_nxt = IDLE;
            end
          end else begin
            sub_nxt = sub_r + 2'd1;
          end
        end
      end
      DEC: begin
        if (!started_r && (dig == 4'd0) && (pos_r != '0)) begin
          // leading zero
          pos_nxt = pos_r - DW'(1);
        end else if (slot_free) begin
          emit        = 1'b1;
          emit_ch     = ASCII_ZERO | {3'b000, dig};
          emit_last   = (pos_r == '0);
          started_nxt = 1'b1;
          pos_nxt     = pos_r - DW'(1);
          if (pos_r == '0) begin
            state_nxt = IDLE;
          end
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  // output register: holds a character while the far side stalls
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_fb_nxt    = out_fb_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = emit_ch;
      out_last_nxt  = emit_last;
      out_fb_nxt    = fb_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
      upper_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        upper_r <= cfg_wr_data;
      end
    end
    neg_r      <= neg_nxt;
    fb_r       <= fb_nxt;
    pos_r      <= pos_nxt;
    sub_r      <= sub_nxt;
    started_r  <= started_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_fb_r   <= out_fb_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_char_code   = out_char_r;
  assign out_last_char   = out_last_r;
  assign out_is_fallback = out_fb_r;

endmodule
